FILE: rtl/kst_pkg.sv
package kst_pkg;

  localparam int KEY_W  = 9;
  localparam int CODE_W = 10;
  localparam int PH_W   = 2;
  localparam int SLOT_W = KEY_W + PH_W;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] REQ_EVENT = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ACT_RELEASE = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;

  localparam logic [PH_W-1:0] PH_UP          = 2'd0;
  localparam logic [PH_W-1:0] PH_JUST_UP     = 2'd1;
  localparam logic [PH_W-1:0] PH_DOWN        = 2'd2;
  localparam logic [PH_W-1:0] PH_JUST_DOWN   = 2'd3;
  localparam logic [PH_W-1:0] PH_STEADY_MASK = 2'h2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SET,
    OP_TICK,
    OP_QUERY
  } kst_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_COMMIT,
    BK_OUT
  } kst_state_t;

  typedef struct packed {
    kst_op_t           op;
    logic [KEY_W-1:0]  key;
    logic [PH_W-1:0]   phase;
  } kst_item_t;

endpackage

FILE: rtl/kst_ram.sv
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/kst_front.sv
module kst_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic signed [kst_pkg::CODE_W-1:0]   in_key_code,
  input  logic [1:0]                          in_key_action,
  input  logic                                q_full,
  output logic                                q_push,
  output kst_pkg::kst_item_t                  q_item
);

  logic negative;

  assign negative = in_key_code[kst_pkg::CODE_W-1];
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Everything that cannot change the table or produce a flag collapses to OP_NONE,
  // so the back end skips the scan for it.
  always_comb begin
    q_item.key   = in_key_code[kst_pkg::KEY_W-1:0];
    q_item.phase = (in_key_action == kst_pkg::ACT_PRESS) ? kst_pkg::PH_JUST_DOWN
                                                          : kst_pkg::PH_JUST_UP;
    q_item.op    = kst_pkg::OP_NONE;
    case (in_req_type)
      kst_pkg::REQ_EVENT: begin
        if (!negative &&
            (in_key_action inside {kst_pkg::ACT_RELEASE, kst_pkg::ACT_PRESS})) begin
          q_item.op = kst_pkg::OP_SET;
        end
      end
      kst_pkg::REQ_TICK: begin
        q_item.op = kst_pkg::OP_TICK;
      end
      kst_pkg::REQ_QUERY: begin
        if (!negative) begin
          q_item.op = kst_pkg::OP_QUERY;
        end
      end
      default: begin
        q_item.op = kst_pkg::OP_NONE;
      end
    endcase
  end

endmodule

FILE: rtl/kst_queue.sv
module kst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  kst_pkg::kst_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output kst_pkg::kst_item_t head
);

  localparam int CNT_W = $clog2(kst_pkg::QDEPTH + 1);

  kst_pkg::kst_item_t          mem_r [kst_pkg::QDEPTH];
  logic [kst_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [kst_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        do_push, do_pop;

  assign full      = (count_r == CNT_W'(kst_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/kst_back.sv
module kst_back #(
  parameter int MAX_KEYS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  kst_pkg::kst_item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_held,
  output logic               out_went_down,
  output logic               out_went_up,
  output logic               out_event_dropped,
  output logic [3:0]         out_entries_in_use
);

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int SW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_KEYS);
  localparam logic [CW:0]   MAX_EXT  = (CW + 1)'(MAX_KEYS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_KEYS - 1);

  kst_pkg::kst_state_t state_r, state_nxt;
  kst_pkg::kst_item_t  item_r, item_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic                pv_r, pv_nxt;
  logic [IW-1:0]       pidx_r, pidx_nxt;
  logic                hit_r, hit_nxt;
  logic [IW-1:0]       hit_idx_r, hit_idx_nxt;
  logic [kst_pkg::PH_W-1:0] hit_ph_r, hit_ph_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IW-1:0]       free_idx_r, free_idx_nxt;
  logic                dropped_r, dropped_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic [MAX_KEYS-1:0] slot_valid_r, slot_valid_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_held_r, out_held_nxt;
  logic                out_down_r, out_down_nxt;
  logic                out_up_r, out_up_nxt;
  logic                out_drop_r, out_drop_nxt;
  logic [3:0]          out_used_r, out_used_nxt;

  logic                      ram_we, ram_re;
  logic [IW-1:0]             ram_waddr, ram_raddr;
  logic [kst_pkg::SLOT_W-1:0] ram_wdata, ram_rdata;

  logic [kst_pkg::KEY_W-1:0] ent_key;
  logic [kst_pkg::PH_W-1:0]  ent_ph;
  logic [kst_pkg::PH_W-1:0]  ent_steady;
  logic                      ent_valid;
  logic [SW-1:0]             used_ext;
  logic                      is_query;

  // Key and phase share one word per slot.
  kst_ram #(
    .WIDTH(kst_pkg::SLOT_W),
    .DEPTH(MAX_KEYS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ent_key    = ram_rdata[kst_pkg::SLOT_W-1:kst_pkg::PH_W];
  assign ent_ph     = ram_rdata[kst_pkg::PH_W-1:0];
  assign ent_steady = ent_ph & kst_pkg::PH_STEADY_MASK;
  assign ent_valid  = slot_valid_r[pidx_r];
  assign used_ext   = SW'(used_r);
  assign is_query   = (item_r.op == kst_pkg::OP_QUERY) && hit_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    scan_nxt       = scan_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_ph_nxt     = hit_ph_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    dropped_nxt    = dropped_r;
    used_nxt       = used_r;
    slot_valid_nxt = slot_valid_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pidx_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = scan_r[IW-1:0];

    out_valid_nxt  = out_valid_r && !out_ready;
    out_held_nxt   = out_held_r;
    out_down_nxt   = out_down_r;
    out_up_nxt     = out_up_r;
    out_drop_nxt   = out_drop_r;
    out_used_nxt   = out_used_r;

    case (state_r)
      kst_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          q_pop          = 1'b1;
          item_nxt       = q_head;
          scan_nxt       = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          dropped_nxt    = 1'b0;
          state_nxt      = (q_head.op == kst_pkg::OP_NONE) ? kst_pkg::BK_OUT
                                                             : kst_pkg::BK_SCAN;
        end
      end

      kst_pkg::BK_SCAN: begin
        // Reads are issued one slot ahead of the compare stage.
        if (scan_r != CNT_MAX) begin
          ram_re   = 1'b1;
          scan_nxt = scan_r + 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = scan_r[IW-1:0];
        end
        if (pv_r) begin
          if (ent_valid && (ent_key == item_r.key)) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pidx_r;
            hit_ph_nxt  = ent_ph;
          end
          if (!ent_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pidx_r;
          end
          // A frame tick settles each phase and frees slots that end up.
          if ((item_r.op == kst_pkg::OP_TICK) && ent_valid) begin
            if (ent_steady == kst_pkg::PH_UP) begin
              slot_valid_nxt[pidx_r] = 1'b0;
              used_nxt               = used_r - CW'(1);
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pidx_r;
              ram_wdata = {ent_key, ent_steady};
            end
          end
          if (pidx_r == LAST_IDX) begin
            state_nxt = (item_r.op == kst_pkg::OP_SET) ? kst_pkg::BK_COMMIT
                                                        : kst_pkg::BK_OUT;
          end
        end
      end

      kst_pkg::BK_COMMIT: begin
        ram_wdata = {item_r.key, item_r.phase};
        if (hit_r) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx_r;
        end else if (({1'b0, used_r} + (CW + 1)'(1)) < MAX_EXT) begin
          ram_we                     = 1'b1;
          ram_waddr                  = free_idx_r;
          slot_valid_nxt[free_idx_r] = 1'b1;
          used_nxt                   = used_r + CW'(1);
        end else begin
          dropped_nxt = 1'b1;
        end
        state_nxt = kst_pkg::BK_OUT;
      end

      kst_pkg::BK_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_held_nxt  = is_query && hit_ph_r[kst_pkg::PH_W-1];
          out_down_nxt  = is_query && (hit_ph_r == kst_pkg::PH_JUST_DOWN);
          out_up_nxt    = is_query && (hit_ph_r == kst_pkg::PH_JUST_UP);
          out_drop_nxt  = dropped_r;
          out_used_nxt  = (used_ext > SW'(15)) ? 4'd15 : used_ext[3:0];
          state_nxt     = kst_pkg::BK_IDLE;
        end
      end

      default: begin
        state_nxt = kst_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kst_pkg::BK_IDLE;
      pv_r         <= 1'b0;
      used_r       <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pv_r         <= pv_nxt;
      used_r       <= used_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    scan_r       <= scan_nxt;
    pidx_r       <= pidx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_ph_r     <= hit_ph_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    dropped_r    <= dropped_nxt;
    out_held_r   <= out_held_nxt;
    out_down_r   <= out_down_nxt;
    out_up_r     <= out_up_nxt;
    out_drop_r   <= out_drop_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_is_held        = out_held_r;
  assign out_went_down      = out_down_r;
  assign out_went_up        = out_up_r;
  assign out_event_dropped  = out_drop_r;
  assign out_entries_in_use = out_used_r;

endmodule

FILE: rtl/key_state_tracker_table.sv
// Key state table. Each transaction on the in_ channel is a key event, a frame
// tick or a query, and produces exactly one transaction on the out_ channel, in
// order. Events record a press or release for a key, ticks turn the fresh
// phases into steady ones and free released keys, queries report the phase of
// one key. Every result carries the dropped flag and the table entries in use.
// A front end classifies each item and places it in a two-entry queue, so
// in_ready stays high until two items are waiting behind the one in progress.
// The back end walks the slot memory one entry per cycle through its single
// read port. An item that touches the table is scanned, an event then also
// commits its slot, and the result is registered; items with no table effect
// go straight to the output register.
// A result waits in the output register while out_ready is low; the back end
// then holds the next item, and the queue keeps accepting until it fills.
// Reset empties the table and the queue and drops any pending result; the
// slot memory itself is not cleared, since per-slot valid bits guard it.
module key_state_tracker_table #(
  parameter int MAX_KEYS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic signed [kst_pkg::CODE_W-1:0] in_key_code,
  input  logic [1:0]                        in_key_action,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_is_held,
  output logic                              out_went_down,
  output logic                              out_went_up,
  output logic                              out_event_dropped,
  output logic [3:0]                        out_entries_in_use
);

  kst_pkg::kst_item_t push_item, head_item;
  logic               q_push, q_full, q_pop, q_not_empty;

  kst_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_key_code  (in_key_code),
    .in_key_action(in_key_action),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  kst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (head_item)
  );

  kst_back #(
    .MAX_KEYS(MAX_KEYS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_head            (head_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_held       (out_is_held),
    .out_went_down     (out_went_down),
    .out_went_up       (out_went_up),
    .out_event_dropped (out_event_dropped),
    .out_entries_in_use(out_entries_in_use)
  );

`ifndef SYNTHESIS
  localparam logic [3:0] CNT_CAP = (MAX_KEYS - 1 > 15) ? 4'd15 : 4'(MAX_KEYS - 1);

  // The table never holds more than MAX_KEYS - 1 keys.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entries_in_use <= CNT_CAP)
    else $error("entries_in_use above table capacity");

  // An event is only dropped when the table is at capacity.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_dropped |-> out_entries_in_use == CNT_CAP)
    else $error("event dropped while table had room");

  // Phase flags are mutually consistent and absent on dropped events.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_went_down && out_went_up) && (!out_went_down || out_is_held)
                  && !(out_went_up && out_is_held)
                  && !(out_event_dropped && (out_is_held || out_went_up)))
    else $error("inconsistent query flags");
`endif

endmodule
